// ----- src/conv3x3_replicate_border_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 replicate-border convolution unit
// Each assertion uses clk_i and rst_ni of the module it is placed in.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_REPLICATE_BORDER_UNIT_MACROS_SVH
`define CONV3X3_REPLICATE_BORDER_UNIT_MACROS_SVH

// Same-cycle implication
`define CBU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cbu_pkg.sv -----
// ----------------------------------------------------------------------------
// cbu_pkg
// Shared constants, types and helpers of the 3x3 convolution unit.
// ----------------------------------------------------------------------------
package cbu_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int SizeW     = 11;
  localparam int PixW      = 16;
  localparam int CoefW     = 16;
  localparam int KrowW     = 48;
  localparam int ProdW     = 32;
  localparam int PsumW     = 34;
  localparam int SumW      = 35;
  localparam int LineW     = 2 * PixW;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 48;
  localparam int OutDataW  = 56;

  typedef enum logic [CfgAddrW-1:0] {
    REG_KROW0  = 3'd0,
    REG_KROW1  = 3'd1,
    REG_KROW2  = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
    logic            done;
  } meta_t;

  typedef struct packed {
    logic [8:0][PixW-1:0] taps;
    meta_t                meta;
  } issue_t;

  // Zero acts as one, oversize acts as the maximum
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v,
                                                input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/conv3x3_replicate_border_unit.sv -----
// Path: fetch, window, tap, product, partial-sum, output. Throughput: one pixel
//   per cycle while each pixel completes at most one result and the output is not
//   stalled; a pixel completing n results (2 at a row end, 2 or 4 on the last row)
//   holds the input until its last result is issued, as the single multiply-add
//   path takes one per cycle. Reset: clears position, window, pipeline and kernel,
//   sets the sizes to maximum; line memory is not cleared and needs no clearing.
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_unit
// 3x3 integer convolution over a raster pixel stream with replicated borders.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_unit
  import cbu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,  // pixel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // out_row, out_col, filtered, zero pad
  output logic                m_axis_tlast,  // run_last
  output logic                m_axis_tuser   // image_done
);

  logic [2:0][KrowW-1:0] kernel_q;
  logic [SizeW-1:0]      width_q, height_q;
  logic [SizeW-1:0]      width_eff, height_eff;
  logic                  issue_valid, issue_ready;
  issue_t                issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= '0;
      width_q  <= SizeW'(MaxWidth);
      height_q <= SizeW'(MaxHeight);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_KROW0:  kernel_q[0] <= cfg_wdata_i[KrowW-1:0];
        REG_KROW1:  kernel_q[1] <= cfg_wdata_i[KrowW-1:0];
        REG_KROW2:  kernel_q[2] <= cfg_wdata_i[KrowW-1:0];
        REG_WIDTH:  width_q     <= cfg_wdata_i[SizeW-1:0];
        REG_HEIGHT: height_q    <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  assign width_eff  = eff_size(width_q, SizeW'(MaxWidth));
  assign height_eff = eff_size(height_q, SizeW'(MaxHeight));

  cbu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .px_valid_i    (s_axis_tvalid),
    .px_ready_o    (s_axis_tready),
    .px_i          (s_axis_tdata),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .issue_valid_o (issue_valid),
    .issue_ready_i (issue_ready),
    .issue_o       (issue)
  );

  cbu_mac u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_ready_o (issue_ready),
    .issue_i       (issue),
    .kernel_i      (kernel_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast),
    .out_done_o    (m_axis_tuser)
  );

endmodule

// ----- src/cbu_lbuf.sv -----
// ----------------------------------------------------------------------------
// cbu_lbuf
// Line memory: one entry per column holds the middle and upper line pixels.
// ----------------------------------------------------------------------------
module cbu_lbuf
  import cbu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [ColW-1:0]  rd_addr_i,
  output logic [LineW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [ColW-1:0]  wr_addr_i,
  input  logic [LineW-1:0] wr_data_i
);

  logic [LineW-1:0] mem [MaxWidth];
  logic [LineW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- src/cbu_front.sv -----
// ----------------------------------------------------------------------------
// cbu_front
// Raster position, line memory fetch and write-back, 3x3 window and the
// sequencer that lists the results completed by each pixel.
// ----------------------------------------------------------------------------
`include "conv3x3_replicate_border_unit_macros.svh"

module cbu_front
  import cbu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             px_valid_i,
  output logic             px_ready_o,
  input  logic [PixW-1:0]  px_i,
  input  logic [SizeW-1:0] width_i,
  input  logic [SizeW-1:0] height_i,
  output logic             issue_valid_o,
  input  logic             issue_ready_i,
  output issue_t           issue_o
);

  // raster position
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            col_wrap;
  logic [ColW-1:0] cur_j;
  logic [RowW:0]   row_inc;
  logic [RowW-1:0] cur_i;
  logic [ColW:0]   j_next;
  logic [RowW:0]   i_next;
  logic            accept;

  // fetch stage
  logic             a_v_q;
  logic [PixW-1:0]  a_px_q;
  logic [RowW-1:0]  a_i_q;
  logic [ColW-1:0]  a_j_q;
  logic             fwd_q;
  logic [LineW-1:0] fwd_data_q;
  logic [LineW-1:0] rd_data;
  logic [LineW-1:0] fetched;
  logic [PixW-1:0]  up_px;
  logic [PixW-1:0]  mid_px;
  logic [LineW-1:0] wr_data;

  // window and result sequencer
  logic [8:0][PixW-1:0] win_q;
  logic            job_v_q;
  logic [RowW-1:0] job_i_q;
  logic [ColW-1:0] job_j_q;
  logic            has_p1_q, has_c1_q, has_c0_q;
  logic            i_ge1_q, i_ge2_q, j_ge1_q, j_ge2_q;
  logic            psel_q, csel_q;
  logic            job_last, job_free, job_load;
  logic            has_p0, has_p1, has_c0, has_c1;
  logic [2:0][1:0] rs, cs;

  assign col_wrap = {1'b0, col_q} >= width_i;
  assign cur_j    = col_wrap ? '0 : col_q;
  assign row_inc  = col_wrap ? {1'b0, row_q} + (RowW+1)'(1) : {1'b0, row_q};
  assign cur_i    = (row_inc >= height_i) ? '0 : row_inc[RowW-1:0];
  assign j_next   = {1'b0, cur_j} + (ColW+1)'(1);
  assign i_next   = {1'b0, cur_i} + (RowW+1)'(1);

  always_comb begin
    col_d = j_next[ColW-1:0];
    row_d = cur_i;
    if (j_next >= width_i) begin
      col_d = '0;
      row_d = (i_next >= height_i) ? '0 : i_next[RowW-1:0];
    end
  end

  assign job_last = !((!csel_q && has_c1_q) || (!psel_q && has_p1_q));
  assign job_free = !job_v_q || (issue_ready_i && job_last);
  assign job_load = a_v_q && job_free;
  assign px_ready_o = !a_v_q || job_free;
  assign accept     = px_valid_i && px_ready_o;

  assign fetched = fwd_q ? fwd_data_q : rd_data;
  assign up_px   = fetched[PixW-1:0];
  assign mid_px  = fetched[LineW-1:PixW];
  // upper line takes the old middle, middle line takes the new pixel
  assign wr_data = {a_px_q, mid_px};

  cbu_lbuf u_lbuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (cur_j),
    .rd_data_o (rd_data),
    .wr_en_i   (job_load),
    .wr_addr_i (a_j_q),
    .wr_data_i (wr_data)
  );

  assign has_p0 = a_i_q != '0;
  assign has_p1 = {1'b0, a_i_q} == height_i - SizeW'(1);
  assign has_c0 = a_j_q != '0;
  assign has_c1 = {1'b0, a_j_q} == width_i - SizeW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      a_v_q   <= 1'b0;
      fwd_q   <= 1'b0;
      job_v_q <= 1'b0;
      win_q   <= '0;
    end else begin
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
        a_px_q <= px_i;
        a_i_q  <= cur_i;
        a_j_q  <= cur_j;
        // same entry written while it is read: take the written beat
        fwd_q      <= job_load && (a_j_q == cur_j);
        fwd_data_q <= wr_data;
      end
      if (accept) begin
        a_v_q <= 1'b1;
      end else if (job_load) begin
        a_v_q <= 1'b0;
        fwd_q <= 1'b0;
      end

      if (job_v_q && issue_ready_i && !job_last) begin
        if (!csel_q && has_c1_q) begin
          csel_q <= 1'b1;
        end else begin
          psel_q <= 1'b1;
          csel_q <= !has_c0_q;
        end
      end else if (job_v_q && issue_ready_i && !job_load) begin
        job_v_q <= 1'b0;
      end

      if (job_load) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= up_px;
        win_q[5] <= mid_px;
        win_q[8] <= a_px_q;
        job_v_q  <= (has_p0 || has_p1) && (has_c0 || has_c1);
        job_i_q  <= a_i_q;
        job_j_q  <= a_j_q;
        has_p1_q <= has_p1;
        has_c1_q <= has_c1;
        has_c0_q <= has_c0;
        i_ge1_q  <= has_p0;
        i_ge2_q  <= a_i_q >= RowW'(2);
        j_ge1_q  <= has_c0;
        j_ge2_q  <= a_j_q >= ColW'(2);
        psel_q   <= !has_p0;
        csel_q   <= !has_c0;
      end
    end
  end

  // clamp neighbour rows and columns onto the window
  always_comb begin
    rs[0] = psel_q ? (i_ge1_q ? 2'd1 : 2'd2) : (i_ge2_q ? 2'd0 : 2'd1);
    rs[1] = psel_q ? 2'd2 : 2'd1;
    rs[2] = 2'd2;
    cs[0] = csel_q ? (j_ge1_q ? 2'd1 : 2'd2) : (j_ge2_q ? 2'd0 : 2'd1);
    cs[1] = csel_q ? 2'd2 : 2'd1;
    cs[2] = 2'd2;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        issue_o.taps[a*3+b] = win_q[4'(rs[a]) * 4'd3 + 4'(cs[b])];
      end
    end
    issue_o.meta.row  = psel_q ? job_i_q : job_i_q - RowW'(1);
    issue_o.meta.col  = csel_q ? job_j_q : job_j_q - ColW'(1);
    issue_o.meta.last = job_last;
    issue_o.meta.done = psel_q && csel_q;
  end

  assign issue_valid_o = job_v_q;

  `CBU_ASSERT_NEXT(a_hold_a, a_v_q && !job_load, a_v_q, "fetch stage lost a pixel")
  `CBU_ASSERT_IMPL(a_stall_a, !px_ready_o, a_v_q && job_v_q, "stall without pending work")
  `CBU_ASSERT_IMPL(a_psel_a, job_v_q && psel_q, has_p1_q, "bottom-row pass without last row")
  `CBU_ASSERT_IMPL(a_fwd_a, fwd_q, a_v_q, "forwarded data without a fetched pixel")

endmodule

// ----- src/cbu_mac.sv -----
// ----------------------------------------------------------------------------
// cbu_mac
// Nine products, two adder levels and the output register of one result.
// ----------------------------------------------------------------------------
module cbu_mac
  import cbu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   issue_valid_i,
  output logic                   issue_ready_o,
  input  issue_t                 issue_i,
  input  logic [2:0][KrowW-1:0]  kernel_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OutDataW-1:0]    out_data_o,
  output logic                   out_last_o,
  output logic                   out_done_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic [8:0][PixW-1:0]  tap_q;
  logic [8:0][ProdW-1:0] prod_q;
  logic [2:0][PsumW-1:0] psum_q;
  logic [SumW-1:0]       sum_q;
  meta_t m1_q, m2_q, m3_q, m4_q;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign issue_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q  <= issue_valid_i;
        tap_q <= issue_i.taps;
        m1_q  <= issue_i.meta;
      end
      if (rdy2) begin
        v2_q <= v1_q;
        m2_q <= m1_q;
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            prod_q[a*3+b] <= ProdW'($signed(tap_q[a*3+b]) *
                                   $signed(kernel_i[a][b*CoefW +: CoefW]));
          end
        end
      end
      if (rdy3) begin
        v3_q <= v2_q;
        m3_q <= m2_q;
        for (int a = 0; a < 3; a++) begin
          psum_q[a] <= PsumW'($signed(prod_q[a*3])) + PsumW'($signed(prod_q[a*3+1]))
                     + PsumW'($signed(prod_q[a*3+2]));
        end
      end
      if (rdy4) begin
        v4_q  <= v3_q;
        m4_q  <= m3_q;
        sum_q <= SumW'($signed(psum_q[0])) + SumW'($signed(psum_q[1]))
               + SumW'($signed(psum_q[2]));
      end
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = {1'b0, sum_q, m4_q.col, m4_q.row};
  assign out_last_o  = m4_q.last;
  assign out_done_o  = m4_q.done;

endmodule

// ----- tb/sv/tb_conv3x3_replicate_border_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_replicate_border_unit
// Streams small images of random and extreme pixels through the convolution
// unit under several kernel and size settings. A local model of the line
// buffers and window predicts every filtered pixel, which is then checked
// field by field against the output beats.
// ----------------------------------------------------------------------------
module tb_conv3x3_replicate_border_unit;
  import cbu_pkg::*;

  typedef struct {
    logic [RowW-1:0]         row;
    logic [ColW-1:0]         col;
    logic signed [SumW-1:0]  sum;
    logic                    run_last;
    logic                    img_done;
  } filt_pix_t;

  class conv_scoreboard;
    logic [KrowW-1:0] krow [3];
    logic [SizeW-1:0] width_reg, height_reg;
    logic [PixW-1:0]  upper [MaxWidth];
    logic [PixW-1:0]  middle [MaxWidth];
    logic [PixW-1:0]  win [9];
    int unsigned      row_pos, col_pos;
    filt_pix_t        pending [$];
    int               n_err;
    int               n_res;

    function void clear();
      for (int k = 0; k < 3; k++) krow[k] = '0;
      width_reg  = SizeW'(MaxWidth);
      height_reg = SizeW'(MaxHeight);
      for (int k = 0; k < 9; k++) win[k] = '0;
      row_pos = 0;
      col_pos = 0;
      n_err   = 0;
      n_res   = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        REG_KROW0:  krow[0] = v;
        REG_KROW1:  krow[1] = v;
        REG_KROW2:  krow[2] = v;
        REG_WIDTH:  width_reg = v[SizeW-1:0];
        REG_HEIGHT: height_reg = v[SizeW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(logic [SizeW-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function logic signed [SumW-1:0] weigh(int unsigned rs [3], int unsigned cs [3]);
      longint acc;
      acc = 0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          acc += longint'($signed(krow[a][16*b +: 16])) *
                 longint'($signed(win[rs[a]*3 + cs[b]]));
      return acc[SumW-1:0];
    endfunction

    function void note_pixel(logic [PixW-1:0] px);
      int unsigned w, h, i, j, ncols, n;
      int unsigned cs [2][3];
      int unsigned ccol [2];
      int unsigned rs [3];
      int unsigned rsel;
      filt_pix_t   fp;
      w = clamp_size(width_reg, MaxWidth);
      h = clamp_size(height_reg, MaxHeight);
      ncols = 0;
      n = 0;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      i = row_pos;
      j = col_pos;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = upper[j];
      win[5] = middle[j];
      win[8] = px;
      upper[j]  = middle[j];
      middle[j] = px;
      if (j >= 1) begin
        cs[ncols] = '{(j >= 2) ? 0 : 1, 1, 2};
        ccol[ncols++] = j - 1;
      end
      if (j == w - 1) begin
        cs[ncols] = '{(j >= 1) ? 1 : 2, 2, 2};
        ccol[ncols++] = j;
      end
      for (int pass = 0; pass < 2; pass++) begin
        if (pass == 0) begin
          if (i < 1) continue;
          rsel = i - 1;
          rs = '{(i >= 2) ? 0 : 1, 1, 2};
        end else begin
          if (i != h - 1) continue;
          rsel = i;
          rs = '{(i >= 1) ? 1 : 2, 2, 2};
        end
        for (int k = 0; k < ncols; k++) begin
          fp.row      = RowW'(rsel);
          fp.col      = ColW'(ccol[k]);
          fp.sum      = weigh(rs, cs[k]);
          fp.run_last = 1'b0;
          fp.img_done = (rsel == h - 1) && (ccol[k] == w - 1);
          pending.push_back(fp);
          n++;
        end
      end
      if (n > 0) pending[$].run_last = 1'b1;
      col_pos = j + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = i + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] d, logic lst, logic usr);
      filt_pix_t fp;
      logic [RowW-1:0]        row;
      logic [ColW-1:0]        col;
      logic signed [SumW-1:0] sum;
      row = d[RowW-1:0];
      col = d[RowW +: ColW];
      sum = d[RowW+ColW +: SumW];
      n_res++;
      if (pending.size() == 0) begin
        $error("unexpected output beat row=%0d col=%0d", row, col);
        n_err++;
        return;
      end
      fp = pending.pop_front();
      if (row !== fp.row) begin
        $error("out_row: expected %0d, got %0d", fp.row, row); n_err++;
      end
      if (col !== fp.col) begin
        $error("out_col: expected %0d, got %0d", fp.col, col); n_err++;
      end
      if (sum !== fp.sum) begin
        $error("filtered: expected %0d, got %0d", fp.sum, sum); n_err++;
      end
      if (lst !== fp.run_last) begin
        $error("run_last: expected %0b, got %0b", fp.run_last, lst); n_err++;
      end
      if (usr !== fp.img_done) begin
        $error("image_done: expected %0b, got %0b", fp.img_done, usr); n_err++;
      end
    endfunction
  endclass

  localparam int StallLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  conv_scoreboard sb;
  int  idle_cycles;
  int  n_pix;
  bit  sink_busy;
  bit  sink_calm;

  conv3x3_replicate_border_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  // Output side: random back-pressure, check each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (sink_busy) m_axis_tready <= 1'b0;
      else if (sink_calm) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no beat accepted for %0d cycles", StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Long receiver stalls now and then
  initial begin
    sink_calm = 1'b1;
    sink_busy = 1'b0;
    forever begin
      repeat ($urandom_range(20, 200)) @(posedge clk_i);
      sink_calm = ~sink_calm;
      if ($urandom_range(0, 3) == 0) begin
        sink_busy = 1'b1;
        repeat ($urandom_range(8, 30)) @(posedge clk_i);
        sink_busy = 1'b0;
      end
    end
  end

  task automatic write_cfg(reg_idx_e idx, logic [CfgDataW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  // Hold tvalid across back-to-back beats, drop it only before a gap
  task automatic send_pixel(logic [PixW-1:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(px);
    n_pix++;
  endtask

  // Drain all expected beats, then let the pipeline settle before reconfiguring
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return PixW'($urandom);
    endcase
  endfunction

  function automatic logic [KrowW-1:0] rand_krow(int mode);
    logic [KrowW-1:0] v;
    for (int b = 0; b < 3; b++)
      case (mode)
        0: v[16*b +: 16] = 16'h8000;
        1: v[16*b +: 16] = 16'h7FFF;
        2: v[16*b +: 16] = 16'($signed($urandom_range(0, 8)) - 4);
        default: v[16*b +: 16] = 16'($urandom);
      endcase
    return v;
  endfunction

  task automatic set_phase(int kmode, logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h);
    write_cfg(REG_KROW0, rand_krow(kmode));
    write_cfg(REG_KROW1, rand_krow(kmode));
    write_cfg(REG_KROW2, rand_krow(kmode));
    write_cfg(REG_WIDTH, w);
    write_cfg(REG_HEIGHT, h);
  endtask

  // One whole image at the current size
  task automatic send_image(int unsigned w, int unsigned h, bit extremes);
    for (int unsigned p = 0; p < w * h; p++)
      send_pixel(extremes ? ((p % 2) ? 16'h8000 : 16'h7FFF) : rand_pixel());
  endtask

  initial begin
    int unsigned w, h;
    sb = new();
    sb.clear();
    idle_cycles = 0;
    n_pix = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme kernels and pixels, degenerate and border sizes
    set_phase(0, 3, 3);
    send_image(3, 3, 1);
    drain();
    set_phase(1, 0, 0);          // zero size acts as one
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    drain();
    set_phase(3, 1, 4);
    send_image(1, 4, 0);
    drain();
    set_phase(3, 4, 1);
    send_image(4, 1, 0);
    drain();
    set_phase(0, 2, 2);
    send_image(2, 2, 1);
    drain();

    // Random images, mostly small; kernel set in every phase
    while (n_pix < 170) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      set_phase($urandom_range(0, 5), CfgDataW'(w), CfgDataW'(h));
      repeat ($urandom_range(1, 2)) send_image(w, h, 0);
      drain();
    end

    // Oversize width acts as the maximum; a part row on a single-row image,
    // then a narrower width wraps the position back to the image start
    set_phase(3, 11'h7FF, 1);
    for (int k = 0; k < 40; k++) send_pixel(rand_pixel());
    drain();
    set_phase(2, 5, 1);
    send_image(5, 1, 0);
    drain();
    write_cfg(REG_HEIGHT, 11'h7FF);
    write_cfg(REG_WIDTH, 1);
    for (int k = 0; k < 3; k++) send_pixel(rand_pixel());
    drain();

    $display("Covered %0d pixels over border, degenerate, oversize and random sizes",
             n_pix);
    $display("with extreme and random kernels; %0d filtered pixels checked", sb.n_res);
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- conv3x3_replicate_border_unit.f -----
+incdir+src
src/cbu_pkg.sv
src/cbu_lbuf.sv
src/cbu_front.sv
src/cbu_mac.sv
src/conv3x3_replicate_border_unit.sv
tb/sv/tb_conv3x3_replicate_border_unit.sv
